// ----- rtl/jgc_pkg.sv -----
package jgc_pkg;

  localparam int CELL_SIZE_W = 13;
  localparam int SALT_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int COORD_W     = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CELL_SIZE = 2'd0;
  localparam cfg_idx_t CFG_SALT      = 2'd1;

  localparam logic [31:0] HASH_MUL_X    = 32'h8da6b343;
  localparam logic [31:0] HASH_MUL_Y    = 32'hd8163841;
  localparam logic [31:0] HASH_MUL_SEED = 32'hcb1ab31f;
  localparam logic [31:0] HASH_MUL_MIX  = 32'h85ebca6b;
  localparam logic [31:0] SALT_X        = 32'h00004b91;
  localparam logic [31:0] SALT_Y        = 32'h000096d3;

endpackage

// ----- rtl/jgc_div.sv -----
module jgc_div #(
  parameter int DW  = 31,
  parameter int CSB = 12,
  parameter int TW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [CSB:0]   divisor_i,
  input  logic [TW-1:0]  side_i,
  output logic           valid_o,
  output logic [DW-1:0]  quo_o,
  output logic [CSB-1:0] rem_o,
  output logic [TW-1:0]  side_o
);

  logic [DW-1:0]  valid_q;
  logic [DW-1:0]  quo_q  [DW];
  logic [CSB-1:0] rem_q  [DW];
  logic [TW-1:0]  side_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_step
    logic [DW-1:0]  d_in;
    logic [CSB-1:0] r_in;
    logic [TW-1:0]  s_in;
    logic           v_in;
    logic [CSB:0]   trial;
    logic [CSB:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign d_in = dividend_i;
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign d_in = quo_q[k-1];
      assign r_in = rem_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = valid_q[k-1];
    end

    assign trial = {r_in, d_in[DW-1]};
    assign ge    = (trial >= divisor_i);
    assign diff  = trial - divisor_i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k]  <= {d_in[DW-2:0], ge};
        rem_q[k]  <= ge ? diff[CSB-1:0] : trial[CSB-1:0];
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[DW-1];
  assign quo_o   = quo_q[DW-1];
  assign rem_o   = rem_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

// ----- rtl/jittered_grid_candidate_test.sv -----
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     world_x_i, world_y_i
// out       output     out_valid_o / out_ready_i   is_candidate_o, jitter_x_o, jitter_y_o
// cfg       input      cfg_we_i                    cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle unless a result held at the output stalls the pipeline.
// Each item passes through two parallel 31-stage restoring dividers, one bit per stage,
// then five hash stages, two more such dividers and the output register.
// Reset clears all valid bits, sets the cell size to one and the salt to zero.
// A result held at the output stalls the whole pipeline; nothing is lost.
module jittered_grid_candidate_test #(
  parameter int CELL_SIZE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             world_x_i,
  input  logic signed [31:0]             world_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_candidate_o,
  output logic [CELL_SIZE_BITS-1:0]      jitter_x_o,
  output logic [CELL_SIZE_BITS-1:0]      jitter_y_o,
  input  logic                           cfg_we_i,
  input  jgc_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [jgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import jgc_pkg::*;

  localparam int CSB  = CELL_SIZE_BITS;
  localparam int DW   = COORD_W - 1;
  localparam int CMPW = (CSB + 1 > CELL_SIZE_W) ? CSB + 1 : CELL_SIZE_W;

  logic [CELL_SIZE_W-1:0] cell_size_q;
  logic [SALT_W-1:0]      salt_q;
  logic [CMPW-1:0]        cs_ext;
  logic [CMPW-1:0]        cs_lim;
  logic [CSB:0]           size_eff;
  logic                   en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= CELL_SIZE_W'(1);
      salt_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_SIZE: cell_size_q <= cfg_wdata_i[CELL_SIZE_W-1:0];
        CFG_SALT:      salt_q      <= cfg_wdata_i[SALT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cs_ext = CMPW'(cell_size_q);
  assign cs_lim = CMPW'(1) << CSB;

  always_comb begin
    if (cs_ext == '0) begin
      size_eff = (CSB+1)'(1);
    end else if (cs_ext > cs_lim) begin
      size_eff = cs_lim[CSB:0];
    end else begin
      size_eff = cs_ext[CSB:0];
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Negative values are divided as their complement; floor quotient and
  // non-negative remainder then follow by inversion and by (s - 1 - r).
  logic          d1_valid;
  logic [DW-1:0] d1_qx;
  logic [DW-1:0] d1_qy;
  logic [CSB-1:0] d1_rx;
  logic [CSB-1:0] d1_ry;
  logic [1:0]    d1_side;

  jgc_div #(.DW(DW), .CSB(CSB), .TW(2)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dividend_i (world_x_i[31] ? ~world_x_i[DW-1:0] : world_x_i[DW-1:0]),
    .divisor_i  (size_eff),
    .side_i     ({world_x_i[31], world_y_i[31]}),
    .valid_o    (d1_valid),
    .quo_o      (d1_qx),
    .rem_o      (d1_rx),
    .side_o     (d1_side)
  );

  jgc_div #(.DW(DW), .CSB(CSB), .TW(1)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dividend_i (world_y_i[31] ? ~world_y_i[DW-1:0] : world_y_i[DW-1:0]),
    .divisor_i  (size_eff),
    .side_i     (1'b0),
    .valid_o    (),
    .quo_o      (d1_qy),
    .rem_o      (d1_ry),
    .side_o     ()
  );

  logic [CSB:0] fix_rx;
  logic [CSB:0] fix_ry;
  assign fix_rx = size_eff - {1'b0, d1_rx} - (CSB+1)'(1);
  assign fix_ry = size_eff - {1'b0, d1_ry} - (CSB+1)'(1);

  logic [4:0]     hv_q;
  logic [31:0]    cx_q, cy_q;
  logic [CSB-1:0] rx_q [5];
  logic [CSB-1:0] ry_q [5];
  logic [31:0]    px_q, py_q, sx_q, sy_q;
  logic [31:0]    ax_q, ay_q;
  logic [31:0]    mx_q, my_q;
  logic [31:0]    hx_q, hy_q;
  logic [31:0]    ax_d, ay_d;
  logic [31:0]    hx_d, hy_d;

  assign ax_d = px_q ^ py_q ^ sx_q;
  assign ay_d = px_q ^ py_q ^ sy_q;
  assign hx_d = mx_q ^ (mx_q >> 16);
  assign hy_d = my_q ^ (my_q >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
    end else if (en) begin
      hv_q <= {hv_q[3:0], d1_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q     <= d1_side[1] ? ~{1'b0, d1_qx} : {1'b0, d1_qx};
      cy_q     <= d1_side[0] ? ~{1'b0, d1_qy} : {1'b0, d1_qy};
      rx_q[0]  <= d1_side[1] ? fix_rx[CSB-1:0] : d1_rx;
      ry_q[0]  <= d1_side[0] ? fix_ry[CSB-1:0] : d1_ry;
      for (int i = 1; i < 5; i++) begin
        rx_q[i] <= rx_q[i-1];
        ry_q[i] <= ry_q[i-1];
      end
      px_q     <= cx_q * HASH_MUL_X;
      py_q     <= cy_q * HASH_MUL_Y;
      sx_q     <= (salt_q ^ SALT_X) * HASH_MUL_SEED;
      sy_q     <= (salt_q ^ SALT_Y) * HASH_MUL_SEED;
      ax_q     <= ax_d ^ (ax_d >> 13);
      ay_q     <= ay_d ^ (ay_d >> 13);
      mx_q     <= ax_q * HASH_MUL_MIX;
      my_q     <= ay_q * HASH_MUL_MIX;
      hx_q     <= hx_d;
      hy_q     <= hy_d;
    end
  end

  logic           d2_valid;
  logic [CSB-1:0] d2_rx;
  logic [CSB-1:0] d2_ry;
  logic [2*CSB+1:0] d2_side;

  jgc_div #(.DW(DW), .CSB(CSB), .TW(2*CSB+2)) u_div_hx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (hv_q[4]),
    .dividend_i (hx_q[31] ? ~hx_q[DW-1:0] : hx_q[DW-1:0]),
    .divisor_i  (size_eff),
    .side_i     ({hx_q[31], hy_q[31], rx_q[4], ry_q[4]}),
    .valid_o    (d2_valid),
    .quo_o      (),
    .rem_o      (d2_rx),
    .side_o     (d2_side)
  );

  jgc_div #(.DW(DW), .CSB(CSB), .TW(1)) u_div_hy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (hv_q[4]),
    .dividend_i (hy_q[31] ? ~hy_q[DW-1:0] : hy_q[DW-1:0]),
    .divisor_i  (size_eff),
    .side_i     (1'b0),
    .valid_o    (),
    .quo_o      (),
    .rem_o      (d2_ry),
    .side_o     ()
  );

  logic [CSB:0]   fix_jx, fix_jy;
  logic [CSB-1:0] jx_d, jy_d;
  logic [CSB-1:0] px_rem, py_rem;

  assign fix_jx = size_eff - {1'b0, d2_rx} - (CSB+1)'(1);
  assign fix_jy = size_eff - {1'b0, d2_ry} - (CSB+1)'(1);
  assign jx_d   = d2_side[2*CSB+1] ? fix_jx[CSB-1:0] : d2_rx;
  assign jy_d   = d2_side[2*CSB]   ? fix_jy[CSB-1:0] : d2_ry;
  assign px_rem = d2_side[2*CSB-1:CSB];
  assign py_rem = d2_side[CSB-1:0];

  logic           out_valid_q;
  logic           hit_q;
  logic [CSB-1:0] jx_q, jy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= (px_rem == jx_d) && (py_rem == jy_d);
      jx_q  <= jx_d;
      jy_q  <= jy_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_candidate_o = hit_q;
  assign jitter_x_o     = jx_q;
  assign jitter_y_o     = jy_q;

`ifndef SYNTH
  a_jx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, jitter_x_o} < size_eff))
    else $error("jitter_x out of cell");
  a_jy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, jitter_y_o} < size_eff))
    else $error("jitter_y out of cell");
  a_unit_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && size_eff == (CSB+1)'(1)) |-> is_candidate_o)
    else $error("unit cell must always be a candidate");
`endif

endmodule

// ----- tb/jittered_grid_candidate_test_tb.sv -----
module jittered_grid_candidate_test_tb;
  import jgc_pkg::*;

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
  } column_t;

  typedef struct packed {
    logic        hit;
    logic [11:0] jx;
    logic [11:0] jy;
  } jitter_t;

  localparam int LATENCY = 68;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [31:0] world_x_i;
  logic signed [31:0] world_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic is_candidate_o;
  logic [11:0] jitter_x_o;
  logic [11:0] jitter_y_o;
  logic cfg_we_i;
  cfg_idx_t cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  column_t pending_cols[$];
  jitter_t expected_jitters[$];
  logic [12:0] model_cell_size;
  logic [31:0] model_salt;
  int mismatches;
  longint cycle_count;
  int burst_left;
  int gap_left;
  int stall_phase;

  jittered_grid_candidate_test #(.CELL_SIZE_BITS(12)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .world_x_i(world_x_i), .world_y_i(world_y_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .is_candidate_o(is_candidate_o), .jitter_x_o(jitter_x_o), .jitter_y_o(jitter_y_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] seed);
    logic [31:0] h;
    h = cx * HASH_MUL_X;
    h ^= cy * HASH_MUL_Y;
    h ^= seed * HASH_MUL_SEED;
    h ^= h >> 13;
    h *= HASH_MUL_MIX;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic longint floor_mod(longint v, longint s);
    longint r;
    r = v % s;
    return (r < 0) ? r + s : r;
  endfunction

  function automatic jitter_t predict_jitter(column_t c);
    longint s;
    longint x;
    longint y;
    longint cx;
    longint cy;
    longint jx;
    longint jy;
    jitter_t r;
    s = (model_cell_size == 0) ? 1 : ((model_cell_size > 4096) ? 4096 : model_cell_size);
    x = c.wx;
    y = c.wy;
    cx = (x - floor_mod(x, s)) / s;
    cy = (y - floor_mod(y, s)) / s;
    jx = floor_mod(longint'($signed(cell_hash(cx[31:0], cy[31:0], model_salt ^ SALT_X))), s);
    jy = floor_mod(longint'($signed(cell_hash(cx[31:0], cy[31:0], model_salt ^ SALT_Y))), s);
    r.hit = (floor_mod(x, s) == jx) && (floor_mod(y, s) == jy);
    r.jx = jx[11:0];
    r.jy = jy[11:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      world_x_i <= '0;
      world_y_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_jitters.push_back(predict_jitter({world_x_i, world_y_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cols.size() > 0) begin
          column_t c;
          c = pending_cols.pop_front();
          in_valid_i <= 1'b1;
          world_x_i <= c.wx;
          world_y_i <= c.wy;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
      mismatches <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_jitters.size() == 0) begin
          if (mismatches < 10) $display("Unexpected item: %b %h %h", is_candidate_o,
                                        jitter_x_o, jitter_y_o);
          mismatches <= mismatches + 1;
        end else begin
          jitter_t e;
          e = expected_jitters.pop_front();
          if (e.hit !== is_candidate_o || e.jx !== jitter_x_o || e.jy !== jitter_y_o) begin
            if (mismatches < 10) $display("Mismatch: expected %b %h %h, got %b %h %h",
                                          e.hit, e.jx, e.jy, is_candidate_o, jitter_x_o,
                                          jitter_y_o);
            mismatches <= mismatches + 1;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 30) out_ready_i <= 1'b1;
      else if (stall_phase < 60) out_ready_i <= ($urandom_range(0, 3) != 0);
      else out_ready_i <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_CELL_SIZE) model_cell_size = data[12:0];
    else if (idx == CFG_SALT) model_salt = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cols.size() > 0 || in_valid_i || expected_jitters.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_coord(int s);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(0, 3 * s);
      2: return 32'h7fff_ffff - $urandom_range(0, 3 * s);
      3: return $urandom_range(0, 4 * s) - 2 * s;
      default: return $urandom_range(0, 20000) - 10000;
    endcase
  endfunction

  task automatic queue_random_phase(int count);
    int s;
    s = (model_cell_size == 0) ? 1 : ((model_cell_size > 4096) ? 4096 : model_cell_size);
    repeat (count) begin
      column_t c;
      c.wx = random_coord(s);
      c.wy = random_coord(s);
      if ($urandom_range(0, 3) == 0) begin
        jitter_t j;
        longint bx;
        longint by;
        bx = longint'(c.wx) - ((longint'(c.wx) % s + s) % s);
        by = longint'(c.wy) - ((longint'(c.wy) % s + s) % s);
        c.wx = bx[31:0];
        c.wy = by[31:0];
        j = predict_jitter(c);
        bx = bx + longint'(j.jx);
        by = by + longint'(j.jy);
        c.wx = bx[31:0];
        c.wy = by[31:0];
      end
      pending_cols.push_back(c);
    end
  endtask

  initial begin
    logic [12:0] sizes[8];
    column_t c;
    sizes = '{13'd0, 13'd4096, 13'd8191, 13'd3, 13'd4095, 13'd17, 13'd1000, 13'd2};
    cycle_count = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CELL_SIZE;
    cfg_wdata_i = '0;
    model_cell_size = 13'd1;
    model_salt = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    c = '{32'sh8000_0000, 32'sh8000_0000}; pending_cols.push_back(c);
    c = '{32'sh7fff_ffff, 32'sh7fff_ffff}; pending_cols.push_back(c);
    c = '{32'sh0, 32'sh0};                 pending_cols.push_back(c);
    c = '{-32'sd1, 32'sd1};                pending_cols.push_back(c);
    wait_drained();
    write_reg(CFG_CELL_SIZE, 32'd4096);
    write_reg(CFG_SALT, 32'hffff_ffff);
    foreach (sizes[i]) begin
      c = '{32'sh8000_0000 + i, 32'sh7fff_ffff - i}; pending_cols.push_back(c);
    end
    c = '{-32'sd1, -32'sd4096}; pending_cols.push_back(c);
    c = '{32'sd4095, 32'sd4096}; pending_cols.push_back(c);
    queue_random_phase(6);
    wait_drained();

    foreach (sizes[i]) begin
      write_reg(CFG_CELL_SIZE, {19'd0, sizes[i]});
      write_reg(CFG_SALT, (i == 2) ? 32'd0 : $urandom);
      if ($urandom_range(0, 1) == 0) write_reg(cfg_idx_t'(2'd3), $urandom);
      queue_random_phase(230);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
